/* sv/cda_pkg.sv */
`timescale 1ns / 1ps
package cda_pkg;

  // Calendar constants
  localparam int LeapCycle      = 400;
  localparam int DaysPerWeek    = 7;
  localparam int YearsPerDecade = 10;
  localparam int YearsCentury   = 100;
  localparam int YearsMillenium = 1000;
  localparam int MonthsPerYear  = 12;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  localparam logic [4:0] LEN_FEB      = 5'd28;
  localparam logic [4:0] LEN_FEB_LEAP = 5'd29;
  localparam logic [4:0] LEN_SHORT    = 5'd30;
  localparam logic [4:0] LEN_LONG     = 5'd31;

  localparam logic [8:0] R400_LAST = 9'(LeapCycle - 1);

  // Requested advance
  typedef enum logic [2:0] {
    ACT_DAYS       = 3'd0,
    ACT_WEEKS      = 3'd1,
    ACT_MONTHS     = 3'd2,
    ACT_YEARS      = 3'd3,
    ACT_DECADES    = 3'd4,
    ACT_CENTURY    = 3'd5,
    ACT_MILLENNIUM = 3'd6
  } action_t;

  // Work handed to the back end
  typedef enum logic [1:0] {
    OP_PASS   = 2'd0,
    OP_DAYS   = 2'd1,
    OP_MONTHS = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_MOD  = 2'd1,
    F_PUSH = 2'd2
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_RUN  = 2'd1,
    B_HOLD = 2'd2
  } back_state_t;

  // Control part of a queued command; year and count travel beside it
  typedef struct packed {
    op_t        op;
    logic       bad;
    logic [3:0] month;
    logic [4:0] day;
    logic [8:0] r400;
  } cmd_ctl_t;

  // Leap test from the year modulo 400
  function automatic logic is_leap(input logic [8:0] r400);
    logic not_century;
    not_century = (r400 != 9'd100) && (r400 != 9'd200) && (r400 != 9'd300);
    return (r400[1:0] == 2'b00) && not_century;
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    case (month) inside
      MON_FEB:                            len = leap ? LEN_FEB_LEAP : LEN_FEB;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_SHORT;
      default:                            len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

/* sv/cda_front.sv */
`timescale 1ns / 1ps
module cda_front #(
  parameter int COUNT_WIDTH = 10,
  parameter int YEAR_WIDTH  = 16,
  parameter int IN_W        = 40,
  parameter int NW          = 13
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // action, count, start_year, start_month, start_day (from bit 0 up)
  input  logic [IN_W-1:0]          s_tdata,
  output logic                     push,
  input  logic                     full,
  output cda_pkg::cmd_ctl_t        cmd_ctl,
  output logic [YEAR_WIDTH-1:0]    cmd_year,
  output logic [NW-1:0]            cmd_count
);
  import cda_pkg::*;

  localparam int CntLo   = 3;
  localparam int YearLo  = CntLo + COUNT_WIDTH;
  localparam int MonLo   = YearLo + YEAR_WIDTH;
  localparam int DayLo   = MonLo + 4;
  localparam int SubShift = YEAR_WIDTH - 9;
  localparam logic [YEAR_WIDTH-1:0] SubInit = YEAR_WIDTH'(LeapCycle << SubShift);
  localparam logic [YEAR_WIDTH-1:0] SubLast = YEAR_WIDTH'(LeapCycle);

  front_state_t state, state_next;

  logic [2:0]             act;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [YEAR_WIDTH-1:0]  year;
  logic [3:0]             month;
  logic [4:0]             day;
  logic [YEAR_WIDTH-1:0]  rem;
  logic [YEAR_WIDTH-1:0]  sub;

  logic                   accept;
  logic                   month_bad;
  logic [NW-1:0]          weeks_days;
  logic [COUNT_WIDTH+3:0] decade_years;

  assign accept = s_tvalid && s_tready;

  // Advance the control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the word, then reduce the year modulo 400 one subtract per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      act   <= s_tdata[2:0];
      cnt   <= s_tdata[YearLo-1:CntLo];
      year  <= s_tdata[MonLo-1:YearLo];
      month <= s_tdata[DayLo-1:MonLo];
      day   <= s_tdata[DayLo+4:DayLo];
      rem   <= s_tdata[MonLo-1:YearLo];
      sub   <= SubInit;
    end else if (state == F_MOD) begin
      if (rem >= sub) begin
        rem <= rem - sub;
      end
      sub <= sub >> 1;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (s_tvalid) state_next = F_MOD;
      F_MOD:  if (sub == SubLast) state_next = F_PUSH;
      F_PUSH: if (!full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_tready = 1'b0;
    push     = 1'b0;
    unique case (state)
      F_IDLE:  s_tready = 1'b1;
      F_MOD:   s_tready = 1'b0;
      F_PUSH:  push = !full;
      default: s_tready = 1'b0;
    endcase
  end

  // Classify the request into a command
  assign month_bad    = (month < MON_JAN) || (month > MON_DEC);
  assign weeks_days   = {cnt, 3'b000} - {3'b000, cnt};
  assign decade_years = {1'b0, cnt, 3'b000} + {3'b000, cnt, 1'b0};

  always_comb begin
    cmd_ctl.op    = OP_PASS;
    cmd_ctl.bad   = month_bad;
    cmd_ctl.month = month;
    cmd_ctl.day   = day;
    cmd_ctl.r400  = rem[8:0];
    cmd_year      = year;
    cmd_count     = '0;
    if (!month_bad) begin
      case (act)
        ACT_DAYS: begin
          cmd_ctl.op = OP_DAYS;
          cmd_count  = NW'(cnt);
        end
        ACT_WEEKS: begin
          cmd_ctl.op = OP_DAYS;
          cmd_count  = weeks_days;
        end
        ACT_MONTHS: begin
          cmd_ctl.op = OP_MONTHS;
          cmd_count  = NW'(cnt);
        end
        ACT_YEARS:      cmd_year = year + YEAR_WIDTH'(cnt);
        ACT_DECADES:    cmd_year = year + YEAR_WIDTH'(decade_years);
        ACT_CENTURY:    cmd_year = year + YEAR_WIDTH'(YearsCentury);
        ACT_MILLENNIUM: cmd_year = year + YEAR_WIDTH'(YearsMillenium);
        default:        cmd_year = year;
      endcase
    end
  end

endmodule

/* sv/cda_fifo.sv */
`timescale 1ns / 1ps
module cda_fifo #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int Depth = 2;

  logic [WIDTH-1:0] mem [Depth];
  logic [$clog2(Depth)-1:0]   wr_ptr;
  logic [$clog2(Depth)-1:0]   rd_ptr;
  logic [$clog2(Depth+1)-1:0] fill;

  assign full  = (fill == ($clog2(Depth+1))'(Depth));
  assign empty = (fill == '0);
  assign rdata = mem[rd_ptr];

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue popped while empty");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= ($clog2(Depth+1))'(Depth))
    else $error("queue fill level out of range");

endmodule

/* sv/cda_back.sv */
`timescale 1ns / 1ps
module cda_back #(
  parameter int YEAR_WIDTH = 16,
  parameter int NW         = 13,
  parameter int OUT_W      = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  empty,
  output logic                  pop,
  input  cda_pkg::cmd_ctl_t     cmd_ctl,
  input  logic [YEAR_WIDTH-1:0] cmd_year,
  input  logic [NW-1:0]         cmd_count,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // new_year, new_month, new_day, bad_month (from bit 0 up)
  output logic [OUT_W-1:0]      m_tdata
);
  import cda_pkg::*;

  localparam logic [NW-1:0] YearMonths = NW'(MonthsPerYear);

  back_state_t state, state_next;

  op_t                   op;
  logic                  bad;
  logic [YEAR_WIDTH-1:0] year, year_next;
  logic [3:0]            month, month_next;
  logic [4:0]            day, day_next;
  logic [8:0]            r400, r400_next;
  logic [NW-1:0]         left, left_next;

  logic                  finished;
  logic                  leap_cur;
  logic                  leap_inc;
  logic [8:0]            r400_inc;
  logic [YEAR_WIDTH-1:0] year_inc;
  logic [4:0]            len_cur;
  logic [4:0]            len_step;
  logic [4:0]            feb_len;
  logic [4:0]            gap;
  logic [NW-1:0]         gap_roll;
  logic [3:0]            month_inc;

  assign finished = (op == OP_PASS) || (left == '0);

  // Advance the control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Load a command, then walk it
  always_ff @(posedge clk) begin
    if (pop) begin
      op    <= cmd_ctl.op;
      bad   <= cmd_ctl.bad;
      year  <= cmd_year;
      month <= cmd_ctl.month;
      day   <= cmd_ctl.day;
      r400  <= cmd_ctl.r400;
      left  <= cmd_count;
    end else if (state == B_RUN) begin
      year  <= year_next;
      month <= month_next;
      day   <= day_next;
      r400  <= r400_next;
      left  <= left_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!empty) state_next = B_RUN;
      B_RUN:  if (finished) state_next = B_HOLD;
      B_HOLD: if (m_tready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    pop      = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      B_IDLE:  pop = !empty;
      B_RUN:   m_tvalid = 1'b0;
      B_HOLD:  m_tvalid = 1'b1;
      default: m_tvalid = 1'b0;
    endcase
  end

  assign m_tdata = OUT_W'({bad, day, month, year});

  // Calendar facts for the current and the following year
  assign year_inc  = year + 1'b1;
  assign r400_inc  = ((year == '1) || (r400 == R400_LAST)) ? 9'd0 : r400 + 9'd1;
  assign leap_cur  = is_leap(r400);
  assign leap_inc  = is_leap(r400_inc);
  assign len_cur   = month_len(leap_cur, month);
  assign month_inc = (month == MON_DEC) ? MON_JAN : month + 4'd1;
  assign len_step  = month_len((month == MON_DEC) ? leap_inc : leap_cur, month_inc);
  assign feb_len   = month_len((month == MON_JAN) ? leap_cur : leap_inc, MON_FEB);
  assign gap       = len_cur - day;
  assign gap_roll  = NW'(gap) + 1'b1;

  // One step: a whole month of days, or a whole year or one month of months
  always_comb begin
    year_next  = year;
    month_next = month;
    day_next   = day;
    r400_next  = r400;
    left_next  = left;
    if (!finished) begin
      case (op)
        OP_DAYS: begin
          if ((day >= len_cur) || (left >= gap_roll)) begin
            // roll into the first of the next month
            month_next = month_inc;
            day_next   = 5'd1;
            if (month == MON_DEC) begin
              year_next = year_inc;
              r400_next = r400_inc;
            end
            left_next = (day >= len_cur) ? left - 1'b1 : left - gap_roll;
          end else begin
            day_next  = day + left[4:0];
            left_next = '0;
          end
        end
        OP_MONTHS: begin
          if (left >= YearMonths) begin
            // twelve steps pass one February exactly once
            year_next = year_inc;
            r400_next = r400_inc;
            day_next  = (day > feb_len) ? feb_len : day;
            left_next = left - YearMonths;
          end else begin
            month_next = month_inc;
            if (month == MON_DEC) begin
              year_next = year_inc;
              r400_next = r400_inc;
            end
            day_next  = (day > len_step) ? len_step : day;
            left_next = left - 1'b1;
          end
        end
        default: left_next = left;
      endcase
    end
  end

  a_progress: assert property (@(posedge clk) disable iff (rst)
    (state == B_RUN && !finished) |=> (left < $past(left)))
    else $error("date walk made no progress");
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_RUN && !bad) |-> ((month >= MON_JAN) && (month <= MON_DEC)))
    else $error("month left the range 1 to 12");
  a_pop_runs: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == B_RUN))
    else $error("popped command not started");

endmodule

/* sv/calendar_date_advance.sv */
`timescale 1ns / 1ps
// Channel | Dir | Fields (bit 0 up)
// s_*     | in  | tdata: action[3], count[COUNT_WIDTH], start_year[YEAR_WIDTH],
//         |     |        start_month[4], start_day[5], zero fill to bytes
// m_*     | out | tdata: new_year[YEAR_WIDTH], new_month[4], new_day[5],
//         |     |        bad_month[1], zero fill to bytes
//
// Front end accepts a word and reduces the year modulo 400 by repeated subtraction,
// then pushes into a two-entry queue.
// Back end crosses one month per step when adding days, adds a whole year or one month per
// step when adding months, and passes the year actions straight through. It hands off one
// command before it pops the next; its month walk sets the item rate.
// Reset (rst, synchronous) empties the queue and returns both ends to idle.
// A stalled output holds the back end; the front end keeps accepting until the queue fills.
module calendar_date_advance #(
  parameter int COUNT_WIDTH = 10,
  parameter int YEAR_WIDTH  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // action, count, start_year, start_month, start_day (from bit 0 up)
  input  logic [((3+COUNT_WIDTH+YEAR_WIDTH+9+7)/8)*8-1:0] s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // new_year, new_month, new_day, bad_month (from bit 0 up)
  output logic [((YEAR_WIDTH+10+7)/8)*8-1:0] m_tdata
);
  import cda_pkg::*;

  localparam int InW   = ((3 + COUNT_WIDTH + YEAR_WIDTH + 9 + 7) / 8) * 8;
  localparam int OutW  = ((YEAR_WIDTH + 10 + 7) / 8) * 8;
  localparam int Nw    = COUNT_WIDTH + 3;
  localparam int CtlW  = $bits(cmd_ctl_t);
  localparam int QW    = CtlW + YEAR_WIDTH + Nw;

  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  empty;
  cmd_ctl_t              f_ctl;
  logic [YEAR_WIDTH-1:0] f_year;
  logic [Nw-1:0]         f_count;
  logic [QW-1:0]         q_wdata;
  logic [QW-1:0]         q_rdata;
  cmd_ctl_t              b_ctl;
  logic [YEAR_WIDTH-1:0] b_year;
  logic [Nw-1:0]         b_count;

  cda_front #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .YEAR_WIDTH (YEAR_WIDTH),
    .IN_W       (InW),
    .NW         (Nw)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .push     (push),
    .full     (full),
    .cmd_ctl  (f_ctl),
    .cmd_year (f_year),
    .cmd_count(f_count)
  );

  // Pack commands through the queue
  assign q_wdata = {f_ctl, f_year, f_count};
  assign b_ctl   = q_rdata[QW-1 -: CtlW];
  assign b_year  = q_rdata[Nw +: YEAR_WIDTH];
  assign b_count = q_rdata[Nw-1:0];

  cda_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(q_wdata),
    .full (full),
    .pop  (pop),
    .rdata(q_rdata),
    .empty(empty)
  );

  cda_back #(
    .YEAR_WIDTH(YEAR_WIDTH),
    .NW        (Nw),
    .OUT_W     (OutW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop      (pop),
    .cmd_ctl  (b_ctl),
    .cmd_year (b_year),
    .cmd_count(b_count),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
